### design/pis_pkg.sv
// ----------------------------------------------------------------------------
// pis_pkg: shared types for the polygon isoline segment block
// Vertex and segment items, and the edge job passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package pis_pkg;

  localparam int CoordW = 32;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] field_value;
    logic signed [CoordW-1:0] contour_level;
    logic                     last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
    logic                     run_end;
  } segment_t;

  // One crossing edge: endpoints, |v1 - level|, |v1 - v2|, and emit control
  typedef struct packed {
    logic [2:0][CoordW-1:0] p1;
    logic [2:0][CoordW-1:0] p2;
    logic [CoordW-1:0]      num;
    logic [CoordW-1:0]      den;
    logic                   emit;
    logic                   run_end;
  } edge_job_t;

endpackage

`default_nettype wire

### design/pis_queue.sv
// ----------------------------------------------------------------------------
// pis_queue: two-entry edge job queue
// Decouples the vertex front end from the interpolation back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pis_queue
  import pis_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire edge_job_t push_job,
  output logic           full,
  input  wire logic      pop,
  output logic           empty,
  output edge_job_t      head_job
);

  edge_job_t   mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign head_job = mem[rd_ptr];

  // store incoming job
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
    end
  end

endmodule

`default_nettype wire

### design/pis_front.sv
// ----------------------------------------------------------------------------
// pis_front: vertex front end
// Tracks facet state, finds the crossing edges of each vertex and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module pis_front
  import pis_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire vertex_t in_data,
  output logic         push,
  output edge_job_t    push_job,
  input  wire logic    q_full
);

  vertex_t    cur;
  vertex_t    prv;
  vertex_t    fst;
  logic [1:0] count;
  logic       have;
  logic       busy;
  logic       phase;

  logic       cross_a;
  logic       cross_b;
  logic       cross_now;
  logic       advance;
  logic       accept;
  edge_job_t  job_a;
  edge_job_t  job_b;

  function automatic logic crosses(input logic signed [CoordW-1:0] v1,
                                   input logic signed [CoordW-1:0] v2,
                                   input logic signed [CoordW-1:0] lv);
    crosses = ((v1 <= lv && lv <= v2) || (v2 <= lv && lv <= v1)) && (v1 != v2);
  endfunction

  function automatic edge_job_t make_job(input vertex_t a, input vertex_t b,
                                         input logic signed [CoordW-1:0] lv,
                                         input logic emit, input logic re);
    edge_job_t         j;
    logic signed [CoordW:0] n;
    logic signed [CoordW:0] m;
    n = {a.field_value[CoordW-1], a.field_value} - {lv[CoordW-1], lv};
    m = {a.field_value[CoordW-1], a.field_value}
      - {b.field_value[CoordW-1], b.field_value};
    if (m[CoordW]) begin
      n = -n;
      m = -m;
    end
    j.p1      = {a.pos_z, a.pos_y, a.pos_x};
    j.p2      = {b.pos_z, b.pos_y, b.pos_x};
    j.num     = n[CoordW-1:0];
    j.den     = m[CoordW-1:0];
    j.emit    = emit;
    j.run_end = re;
    return j;
  endfunction

  // classify both edges of the held vertex
  always_comb begin
    cross_a = (count != 2'd0)
            && crosses(prv.field_value, cur.field_value, cur.contour_level);
    cross_b = cur.last_vertex && (count == 2'd2)
            && crosses(cur.field_value, fst.field_value, cur.contour_level);
    job_a   = make_job(prv, cur, cur.contour_level, have, !cross_b);
    job_b   = make_job(cur, fst, cur.contour_level, have || cross_a, 1'b1);
  end

  assign cross_now = phase ? cross_b : cross_a;
  assign push      = busy && cross_now && !q_full;
  assign push_job  = phase ? job_b : job_a;
  assign advance   = busy && (!cross_now || !q_full);
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;

  // hold the vertex payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= in_data;
      if (count == 2'd0) fst <= in_data;
    end
    if (advance && phase) prv <= cur;
  end

  // step through the incoming and closing edges, then update facet state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      count <= 2'd0;
      have  <= 1'b0;
    end else if (accept) begin
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (advance) begin
      if (!phase) begin
        phase <= 1'b1;
      end else begin
        busy <= 1'b0;
        if (cur.last_vertex) begin
          count <= 2'd0;
          have  <= 1'b0;
        end else begin
          if (count != 2'd2) count <= count + 2'd1;
          have <= have || cross_a;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/pis_back.sv
// ----------------------------------------------------------------------------
// pis_back: crossing point back end
// Multiplies, divides bit-serially and emits segments between crossings.
// ----------------------------------------------------------------------------
`default_nettype none

module pis_back
  import pis_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_empty,
  input  wire edge_job_t head_job,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output segment_t       out_data
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StInit = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;
  localparam int         StepW  = $clog2(CoordW);

  logic [2:0]              state;
  logic [StepW-1:0]        step;
  logic [2:0][CoordW-1:0]  base;
  logic [2:0]              neg;
  logic [2:0][CoordW-1:0]  mag;
  logic [2:0][2*CoordW-1:0] prod;
  logic [2:0][CoordW-1:0]  rem;
  logic [2:0][CoordW-1:0]  quo;
  logic [CoordW-1:0]       num;
  logic [CoordW-1:0]       den;
  logic                    emit;
  logic                    run_end;
  logic [2:0][CoordW-1:0]  last_pt;
  logic [2:0][CoordW-1:0]  pt;
  logic                    slot_free;
  logic                    fin_go;

  assign pop       = (state == StIdle) && !q_empty;
  assign slot_free = !out_valid || !out_stall;
  assign fin_go    = (state == StFin) && (!emit || slot_free);

  // final crossing point per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = neg[i] ? base[i] - quo[i] : base[i] + quo[i];
    end
  end

  // datapath per lane
  always_ff @(posedge clk) begin
    logic signed [CoordW:0] d;
    logic [2*CoordW-1:0]    sum;
    logic [CoordW:0]        t;
    case (state)
      StIdle: begin
        num     <= head_job.num;
        den     <= head_job.den;
        emit    <= head_job.emit;
        run_end <= head_job.run_end;
        for (int i = 0; i < 3; i++) begin
          d = {head_job.p2[i][CoordW-1], head_job.p2[i]}
            - {head_job.p1[i][CoordW-1], head_job.p1[i]};
          base[i] <= head_job.p1[i];
          neg[i]  <= d[CoordW];
          mag[i]  <= d[CoordW] ? CoordW'(-d) : d[CoordW-1:0];
        end
      end
      StMul: begin
        for (int i = 0; i < 3; i++) begin
          prod[i] <= mag[i] * num;
        end
      end
      StInit: begin
        for (int i = 0; i < 3; i++) begin
          sum    = prod[i] + {{(CoordW+1){1'b0}}, den[CoordW-1:1]};
          rem[i] <= sum[2*CoordW-1:CoordW];
          quo[i] <= sum[CoordW-1:0];
        end
      end
      StDiv: begin
        for (int i = 0; i < 3; i++) begin
          t = {rem[i], quo[i][CoordW-1]};
          if (t >= {1'b0, den}) begin
            t      = t - {1'b0, den};
            quo[i] <= {quo[i][CoordW-2:0], 1'b1};
          end else begin
            quo[i] <= {quo[i][CoordW-2:0], 1'b0};
          end
          rem[i] <= t[CoordW-1:0];
        end
      end
      default: begin
      end
    endcase
    if (fin_go) last_pt <= pt;
  end

  // sequence one job
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      step  <= '0;
    end else begin
      case (state)
        StIdle: if (!q_empty) state <= StMul;
        StMul:  state <= StInit;
        StInit: begin
          state <= StDiv;
          step  <= '0;
        end
        StDiv: begin
          step <= step + 1'b1;
          if (step == StepW'(CoordW - 1)) state <= StFin;
        end
        StFin:  if (fin_go) state <= StIdle;
        default: state <= StIdle;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go && emit) begin
      out_data.start_x <= last_pt[0];
      out_data.start_y <= last_pt[1];
      out_data.start_z <= last_pt[2];
      out_data.end_x   <= pt[0];
      out_data.end_y   <= pt[1];
      out_data.end_z   <= pt[2];
      out_data.run_end <= run_end;
    end
  end

endmodule

`default_nettype wire

### design/polygon_isoline_segments.sv
// A vertex is taken, then its incoming and closing edges are classified in turn.
// Each crossing edge then passes the back end: one multiply, one rounding add
// and a 32-step bit-serial divide, run side by side for the three coordinates.
// The front end takes a new vertex once both edges of the last are classified;
// the back end takes one crossing edge at a time. Reset clears the facet,
// queue and handshake state; datapath registers are loaded before use.
// ----------------------------------------------------------------------------
// polygon_isoline_segments: contour segments across a polygon facet
// Front end classifies vertex edges, back end interpolates crossing points.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_isoline_segments
  import pis_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire vertex_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output segment_t      out_data
);

  logic      push;
  logic      q_full;
  logic      pop;
  logic      q_empty;
  edge_job_t push_job;
  edge_job_t head_job;

  pis_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  pis_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  pis_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### sim/pis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_checker: segment predictor and comparator
// Watches the vertex and segment channels, computes the expected contour
// segments for every accepted vertex and compares each accepted segment.
// ----------------------------------------------------------------------------
`default_nettype none

module pis_checker
  import pis_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire vertex_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_stall,
  input  wire segment_t out_data,
  output int            fail_count,
  output int            pending_count
);

  // facet state of the predictor
  logic signed [31:0] fst_x, fst_y, fst_z, fst_v;
  logic signed [31:0] prv_x, prv_y, prv_z, prv_v;
  logic [1:0]         vtx_count;
  logic               have_cross;
  logic signed [31:0] cross_x, cross_y, cross_z;

  segment_t seg_queue[$];

  initial pending_count = 0;

  // round-to-nearest interpolation between a and b at n/m
  function automatic logic signed [31:0] lerp_coord(logic signed [31:0] a,
      logic signed [31:0] b, longint unsigned n, longint unsigned m);
    longint d;
    longint unsigned mag, q;
    d = longint'(b) - longint'(a);
    mag = (d < 0) ? -d : d;
    q = (mag * n + m / 2) / m;
    lerp_coord = (d < 0) ? 32'(longint'(a) - longint'(q))
                         : 32'(longint'(a) + longint'(q));
  endfunction

  // find the level crossing on one edge and queue a segment if one is open
  task automatic cross_edge(logic signed [31:0] x1, y1, z1, v1,
      logic signed [31:0] x2, y2, z2, v2, logic signed [31:0] lv, inout int cnt);
    longint n, m;
    logic signed [31:0] px, py, pz;
    segment_t seg;
    if (!((v1 <= lv && lv <= v2) || (v2 <= lv && lv <= v1))) return;
    if (v1 == v2) return;
    n = longint'(v1) - longint'(lv);
    m = longint'(v1) - longint'(v2);
    if (m < 0) begin
      n = -n;
      m = -m;
    end
    px = lerp_coord(x1, x2, n, m);
    py = lerp_coord(y1, y2, n, m);
    pz = lerp_coord(z1, z2, n, m);
    if (have_cross) begin
      seg = '{cross_x, cross_y, cross_z, px, py, pz, 1'b0};
      seg_queue.push_back(seg);
      cnt++;
    end
    cross_x = px;
    cross_y = py;
    cross_z = pz;
    have_cross = 1'b1;
  endtask

  task automatic predict_vertex(vertex_t vin);
    int cnt;
    cnt = 0;
    if (vtx_count == 0) begin
      fst_x = vin.pos_x;
      fst_y = vin.pos_y;
      fst_z = vin.pos_z;
      fst_v = vin.field_value;
    end else begin
      cross_edge(prv_x, prv_y, prv_z, prv_v, vin.pos_x, vin.pos_y, vin.pos_z,
                 vin.field_value, vin.contour_level, cnt);
      if (vin.last_vertex && vtx_count >= 2)
        cross_edge(vin.pos_x, vin.pos_y, vin.pos_z, vin.field_value,
                   fst_x, fst_y, fst_z, fst_v, vin.contour_level, cnt);
    end
    prv_x = vin.pos_x;
    prv_y = vin.pos_y;
    prv_z = vin.pos_z;
    prv_v = vin.field_value;
    if (vtx_count < 2) vtx_count++;
    if (vin.last_vertex) begin
      vtx_count = 0;
      have_cross = 1'b0;
    end
    if (cnt > 0) seg_queue[$].run_end = 1'b1;
  endtask

  // compare one field and report a mismatch
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    segment_t exp_seg;
    if (rst) begin
      fst_x = 0; fst_y = 0; fst_z = 0; fst_v = 0;
      prv_x = 0; prv_y = 0; prv_z = 0; prv_v = 0;
      vtx_count = 0;
      have_cross = 1'b0;
      cross_x = 0; cross_y = 0; cross_z = 0;
      seg_queue.delete();
      fail_count = 0;
    end else begin
      // advance the predictor on an accepted vertex
      if (in_valid && !in_stall) predict_vertex(in_data);
      // compare an accepted segment with the oldest expectation
      if (out_valid && !out_stall) begin
        if (seg_queue.size() == 0) begin
          $error("unexpected segment %h", out_data);
          fail_count++;
        end else begin
          exp_seg = seg_queue.pop_front();
          check_field("start_x", exp_seg.start_x, out_data.start_x);
          check_field("start_y", exp_seg.start_y, out_data.start_y);
          check_field("start_z", exp_seg.start_z, out_data.start_z);
          check_field("end_x", exp_seg.end_x, out_data.end_x);
          check_field("end_y", exp_seg.end_y, out_data.end_y);
          check_field("end_z", exp_seg.end_z, out_data.end_z);
          check_field("run_end", 32'(exp_seg.run_end), 32'(out_data.run_end));
        end
      end
    end
    pending_count = seg_queue.size();
  end

endmodule

`default_nettype wire

### sim/tb_polygon_isoline_segments.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_isoline_segments: testbench for the contour segment block
// Drives directed and random polygon facets under several idle patterns and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_polygon_isoline_segments;
  import pis_pkg::*;

  localparam int CycleLimit = 2000000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  vertex_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  segment_t out_data;
  int       fail_count;
  int       pending_count;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic signed [31:0] facet_level;

  always #6 clk = ~clk;

  polygon_isoline_segments u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  pis_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending_count(pending_count)
  );

  // stall the receiver at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // end the run on a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_polygon_isoline_segments NOT OK");
      $finish;
    end
  end

  // present one vertex and hold it until accepted; valid stays up afterwards
  // until the next vertex, an idle cycle or a drain takes it down
  task automatic send_vertex(vertex_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    rand_word = $urandom;
  endfunction

  // field value near the level, often exactly on it
  function automatic logic signed [31:0] near_value(logic signed [31:0] lv);
    case ($urandom_range(5))
      0: near_value = lv;
      1: near_value = rand_word();
      default: near_value = lv + 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic send_facet(int nv, bit wide);
    vertex_t v;
    for (int i = 0; i < nv; i++) begin
      v.pos_x = wide ? rand_word() : 32'($signed($urandom_range(2000000)) - 1000000);
      v.pos_y = wide ? rand_word() : 32'($signed($urandom_range(2000000)) - 1000000);
      v.pos_z = rand_word();
      v.contour_level = ($urandom_range(15) == 0) ? rand_word() : facet_level;
      v.field_value = near_value(v.contour_level);
      v.last_vertex = (i == nv - 1);
      send_vertex(v);
    end
  endtask

  // let the checker take in the last vertex, then wait for every segment
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    vertex_t v;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, on-level vertices, equal values, short facets
    v = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 1'b0};
    send_vertex(v);
    v = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 1'b0};
    send_vertex(v);
    v = '{0, 0, 0, 32'sh80000000, 0, 1'b1};
    send_vertex(v);
    v = '{1, 2, 3, 5, 5, 1'b0};
    send_vertex(v);
    v = '{4, 5, 6, 5, 5, 1'b0};
    send_vertex(v);
    v = '{7, 8, 9, 5, 5, 1'b1};
    send_vertex(v);
    v = '{10, 20, 30, 0, 1, 1'b1};
    send_vertex(v);
    v = '{10, 20, 30, 0, 1, 1'b0};
    send_vertex(v);
    v = '{-10, 40, 30, 2, 1, 1'b1};
    send_vertex(v);
    v = '{-1, -1, -1, -1, 0, 1'b0};
    send_vertex(v);
    v = '{1, 1, 1, 1, 0, 1'b0};
    send_vertex(v);
    v = '{3, -3, 3, 0, 0, 1'b0};
    send_vertex(v);
    v = '{-3, 3, -3, -2, 0, 1'b1};
    send_vertex(v);
    v = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          32'sh7fffffff, 1'b0};
    send_vertex(v);
    v = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh7fffffff, 1'b0};
    send_vertex(v);
    v = '{-5, -5, -5, 32'sh7ffffffe, 32'sh80000000, 1'b1};
    send_vertex(v);
    wait_drain();

    // random facets over the idle phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int n = 0; n < 325; ) begin
        int nv;
        facet_level = ($urandom_range(3) == 0) ? rand_word()
                      : 32'($signed($urandom_range(200000)) - 100000);
        nv = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
        send_facet(nv, $urandom_range(3) == 0);
        n += nv;
        if ($urandom_range(20) == 0) wait_drain();
      end
      wait_drain();
    end

    if (fail_count == 0) begin
      $display("tb_polygon_isoline_segments OK");
    end else begin
      $display("tb_polygon_isoline_segments NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

### polygon_isoline_segments.f
design/pis_pkg.sv
design/pis_queue.sv
design/pis_front.sv
design/pis_back.sv
design/polygon_isoline_segments.sv
sim/pis_checker.sv
sim/tb_polygon_isoline_segments.sv
